// ===== rtl/core/sm3_pkg.sv =====
// SM3 hash engine shared package: payload types, constants and round functions.
// No dependencies.
package sm3_pkg;

	typedef struct packed {
		logic [31:0] msg_word;
		logic [2:0]  valid_bytes;
		logic        msg_end;
	} sm3_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sm3_out_t;

	localparam logic [31:0] IV [8] = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7,
		32'hda8a0600, 32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	// datapath commands
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_WRITE,    // merge bytes into the block buffer
		CMD_LOAD,     // start compression: window <- block, regs <- chain
		CMD_ROUND,    // one compression round
		CMD_FOLD,     // chain ^= regs
		CMD_RESTART   // chain <- IV
	} sm3_cmd_e;

	typedef struct packed {
		sm3_cmd_e    cmd;
		logic [3:0]  widx;
		logic [31:0] wdata;
		logic [3:0]  wmask;
		logic [5:0]  round;
		logic [2:0]  rd_idx;
	} sm3_ctl_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

// ===== rtl/core/sm3_datapath.sv =====
// SM3 datapath: block buffer, chaining value, round registers, message window.
// Depends on sm3_pkg.
module sm3_datapath (
	input  logic            clk,
	input  sm3_pkg::sm3_ctl_t ctl,
	output logic [31:0]     chain_word
);
	import sm3_pkg::*;

	logic [31:0] block_q [16];
	logic [31:0] chain_q [8];
	logic [31:0] r_q [8];
	logic [31:0] w_q [16];

	logic [31:0] wnew, wj, wj4, tj, ff, gg, a12, ss1, ss2, tt1, tt2;

	always_comb begin
		wnew = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
		wj   = w_q[0];
		wj4  = w_q[4];
		tj   = (ctl.round < 6'd16) ? T_LOW : T_HIGH;
		if (ctl.round < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		a12 = rotl(r_q[0], 5'd12);
		ss1 = rotl(a12 + r_q[4] + rotl(tj, ctl.round[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		tt1 = ff + r_q[3] + ss2 + (wj ^ wj4);
		tt2 = gg + r_q[7] + ss1 + wj;
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_WRITE: begin
				for (int b = 0; b < 4; b++)
					if (ctl.wmask[b])
						block_q[ctl.widx][b*8 +: 8] <= ctl.wdata[b*8 +: 8];
			end
			CMD_LOAD: begin
				for (int i = 0; i < 16; i++) w_q[i] <= block_q[i];
				for (int i = 0; i < 8; i++) r_q[i] <= chain_q[i];
			end
			CMD_ROUND: begin
				// window shifts one word per round; slot 0 is W[j]
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wnew;
				r_q[0] <= tt1;
				r_q[1] <= r_q[0];
				r_q[2] <= rotl(r_q[1], 5'd9);
				r_q[3] <= r_q[2];
				r_q[4] <= p0(tt2);
				r_q[5] <= r_q[4];
				r_q[6] <= rotl(r_q[5], 5'd19);
				r_q[7] <= r_q[6];
			end
			CMD_FOLD: begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ r_q[i];
			end
			CMD_RESTART: begin
				for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
			end
			default: ;
		endcase
	end

	assign chain_word = chain_q[ctl.rd_idx];

endmodule

// ===== rtl/core/sm3_ctrl.sv =====
// SM3 controller: byte packing, padding, round sequencing and digest output.
// Depends on sm3_pkg.
module sm3_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sm3_pkg::sm3_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sm3_pkg::sm3_out_t out_data,
	output sm3_pkg::sm3_ctl_t ctl,
	input  logic [31:0]       chain_word
);
	import sm3_pkg::*;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_BYTES, S_ROUND, S_FOLD, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MSG, PH_PAD, PH_ZERO, PH_LEN
	} phase_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic [31:0] word_q;
	logic [2:0]  cnt_q;
	logic        end_q;
	phase_t      phase_q;
	logic [5:0]  round_q;
	logic [2:0]  oidx_q;
	logic        ovalid_q;
	logic [63:0] bits_q;
	// first cycle of the round state loads window and working registers
	logic        load_q;

	logic [7:0]  cur_byte;
	logic        push;
	logic [5:0]  fill_n;

	always_comb begin
		cur_byte = 8'h00;
		push     = 1'b0;
		unique case (phase_q)
			PH_MSG: begin
				push = cnt_q != 3'd0;
				cur_byte = word_q[31:24];
			end
			PH_PAD: begin
				push = 1'b1;
				cur_byte = PAD_BYTE;
			end
			PH_ZERO: push = fill_q != 6'd56;
			PH_LEN: begin
				push = 1'b1;
				cur_byte = bits_q[63:56];
			end
			default: ;
		endcase
		fill_n = fill_q + 6'd1;

		ctl = '0;
		ctl.cmd = CMD_NOP;
		ctl.round = round_q;
		ctl.rd_idx = oidx_q;
		ctl.widx = fill_q[5:2];
		ctl.wdata = {4{cur_byte}};
		ctl.wmask = 4'b1000 >> fill_q[1:0];
		unique case (state_q)
			S_INIT:  ctl.cmd = CMD_RESTART;
			S_BYTES: begin
				if (push) ctl.cmd = CMD_WRITE;
			end
			S_ROUND: ctl.cmd = load_q ? CMD_LOAD : CMD_ROUND;
			S_FOLD:  ctl.cmd = CMD_FOLD;
			S_OUT:   ctl.cmd = (out_ready && oidx_q == 3'd7 && ovalid_q) ? CMD_RESTART
				: CMD_NOP;
			default: ;
		endcase
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = ovalid_q;
	assign out_data.digest_word = chain_word;
	assign out_data.word_index  = oidx_q;
	assign out_data.last_word   = oidx_q == 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			fill_q   <= '0;
			total_q  <= '0;
			cnt_q    <= '0;
			end_q    <= 1'b0;
			phase_q  <= PH_MSG;
			round_q  <= '0;
			oidx_q   <= '0;
			ovalid_q <= 1'b0;
			load_q   <= 1'b0;
			word_q   <= '0;
			bits_q   <= '0;
		end else begin
			load_q <= 1'b0;
			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						word_q  <= in_data.msg_word;
						cnt_q   <= (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
						end_q   <= in_data.msg_end;
						phase_q <= PH_MSG;
						total_q <= total_q + 61'((in_data.valid_bytes > 3'd4) ? 3'd4
							: in_data.valid_bytes);
						state_q <= S_BYTES;
					end
				end
				S_BYTES: begin
					if (push) begin
						fill_q <= fill_n;
						unique case (phase_q)
							PH_MSG: begin
								word_q <= word_q << 8;
								cnt_q  <= cnt_q - 3'd1;
							end
							PH_PAD: phase_q <= PH_ZERO;
							PH_LEN: begin
								bits_q <= bits_q << 8;
								cnt_q  <= cnt_q - 3'd1;
							end
							default: ;
						endcase
						if (fill_q == 6'd63) begin
							fill_q  <= '0;
							load_q  <= 1'b1;
							round_q <= '0;
							state_q <= S_ROUND;
						end
					end else begin
						unique case (phase_q)
							PH_MSG: begin
								if (end_q) begin
									phase_q <= PH_PAD;
									bits_q  <= {total_q, 3'b000};
								end else
									state_q <= S_IDLE;
							end
							PH_ZERO: begin
								phase_q <= PH_LEN;
								cnt_q   <= 3'd0;
							end
							default: ;
						endcase
					end
					if (phase_q == PH_LEN && push && cnt_q == 3'd1)
						end_q <= 1'b0;
				end
				S_ROUND: begin
					if (!load_q) begin
						round_q <= round_q + 6'd1;
						if (round_q == 6'd63) state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					// length phase: cnt counts down from 0 through 8 bytes
					if (phase_q == PH_LEN && cnt_q == 3'd0) begin
						state_q  <= S_OUT;
						ovalid_q <= 1'b1;
						oidx_q   <= '0;
					end else
						state_q <= S_BYTES;
				end
				S_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							ovalid_q <= 1'b0;
							total_q  <= '0;
							end_q    <= 1'b0;
							phase_q  <= PH_MSG;
							cnt_q    <= '0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT)
		else $error("output valid outside digest state");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken during digest");
	assert property (@(posedge clk) disable iff (!arst_n)
		load_q |-> state_q == S_ROUND)
		else $error("load outside round state");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> cnt_q == 3'd0)
		else $error("bytes left over in idle");

endmodule

// ===== rtl/core/sm3_hash_engine_top.sv =====
// SM3 hash engine top level: controller plus datapath.
// Depends on sm3_pkg, sm3_ctrl, sm3_datapath.
//
// Input channel (in_valid/in_ready/in_data): big-endian words of up to four
// message bytes; msg_end marks the last item of a message.
// Output channel (out_valid/out_ready/out_data): eight digest words, indexes
// 0..7, last_word on the eighth. After the eighth the engine restarts from
// the initial vector for the next message.
// Each item is accepted in the idle state, its bytes are written one at a
// time by the byte-serial packer, and the engine then returns to idle; no
// new item is taken before that. Every 64th byte starts a compression: a
// load, 64 rounds (one round per cycle on a single round unit) and a fold.
// A message end pads byte by byte (9 to 72 bytes, one or two compressions)
// before the digest appears; the eight words then leave one per cycle while
// out_ready is high.
// Reset loads the initial vector in the first cycle; no item is taken
// until then. A stalled receiver holds the current digest word and the
// engine accepts no input until all eight words are taken.
module sm3_hash_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sm3_pkg::sm3_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sm3_pkg::sm3_out_t out_data
);
	import sm3_pkg::*;

	sm3_ctl_t    ctl;
	logic [31:0] chain_word;

	sm3_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data,
		.ctl, .chain_word
	);

	sm3_datapath u_dp (.clk, .ctl, .chain_word);

endmodule
